@@ hdl/pdd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the differential-drive PID steering core.
// ---------------------------------------------------------------------------
package pdd_pkg;

    // Sample and duty widths
    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Control constants
    localparam int LOST_ERROR   = 500;
    localparam int MARKER_SPEED = 1000;
    localparam int DRIVE_MAX    = 1000;
    localparam int INT_SCALE    = 50;
    localparam int MAX_BASE     = 255 * 4;

    // Drive numerators are held to this range; beyond it the floor order
    // and the clamped duty no longer change
    localparam int NUM_LOW  = -INT_SCALE;
    localparam int NUM_HIGH = (MAX_BASE + 1) * INT_SCALE;

    // Floor division by 50 as multiply and shift, exact up to NUM_HIGH - NUM_LOW
    localparam int DIV50_SHIFT = 22;
    localparam int DIV50_MUL   = ((1 << DIV50_SHIFT) + INT_SCALE - 1) / INT_SCALE;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P          = 3'd0,
        CFG_GAIN_I          = 3'd1,
        CFG_GAIN_D          = 3'd2,
        CFG_CRUISE_SPEED    = 3'd3,
        CFG_LEFT_THRESHOLD  = 3'd4,
        CFG_RIGHT_THRESHOLD = 3'd5,
        CFG_CENTER_HIGH     = 3'd6,
        CFG_INTEGRAL_LIMIT  = 3'd7
    } t_cfg_idx;

    // Input beat: three sensor samples
    typedef struct packed {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
        logic [SAMPLE_W-1:0] center_sample;
    } t_in_beat;

    // Output beat: two motor duties
    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
    } t_out_beat;

endpackage

@@ hdl/pid_differential_drive_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_differential_drive_core
// Line-following PID steering: sensor samples in, left/right PWM duties out.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle unless the output stalls; the error and
// integral state closes its loop inside the first stage, so back-to-back
// beats see each other's update.
// Stages: input register, error/integral, PID sum, divide/select/clamp output.
// Reset (synchronous, active low) clears config, error/integral state and valids.
module pid_differential_drive_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pdd_pkg::t_in_beat                   i_in_beat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pdd_pkg::t_out_beat                  o_out_beat,
    input  logic                                i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pdd_pkg::CFG_W-1:0]           i_cfg_data
);

    // Configuration registers
    logic [7:0] r_gain_p, r_gain_i, r_gain_d, r_cruise_speed;
    logic [7:0] r_left_thr, r_right_thr, r_center_high, r_int_limit;

    // Controller state
    logic signed [10:0] r_last_error;
    logic signed [14:0] r_integral;

    // Pipeline valids and payload
    logic               r_in_valid, r_a_valid, r_b_valid, r_out_valid;
    pdd_pkg::t_in_beat  r_in;
    logic signed [10:0] r_a_e;
    logic signed [11:0] r_a_d;
    logic signed [14:0] r_a_acc;
    logic [10:0]        r_a_base;
    logic [15:0]        r_b_ml, r_b_mr;
    logic [10:0]        r_b_base;
    pdd_pkg::t_out_beat r_out;

    // Stage advance chain
    logic out_rdy, b_rdy, a_rdy, in_rdy;

    assign out_rdy = !r_out_valid || i_out_ready;
    assign b_rdy   = !r_b_valid || out_rdy;
    assign a_rdy   = !r_a_valid || b_rdy;
    assign in_rdy  = !r_in_valid || a_rdy;

    assign o_in_ready  = in_rdy;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Error, integral and base speed from the input register
    logic               s0_ldet, s0_rdet;
    logic signed [10:0] s0_e;
    logic signed [19:0] s0_ei, s0_acc_raw, s0_cap, s0_acc_clamp;
    logic [13:0]        s0_cap_u;
    logic signed [11:0] s0_d;
    logic [10:0]        s0_base;

    always_comb begin
        s0_ldet = r_in.left_sample > {2'b00, r_left_thr};
        s0_rdet = r_in.right_sample > {2'b00, r_right_thr};
        if (!s0_ldet && !s0_rdet) begin
            if (r_last_error <= 11'sd0) begin
                s0_e = -11'(pdd_pkg::LOST_ERROR);
            end else begin
                s0_e = 11'(pdd_pkg::LOST_ERROR);
            end
        end else begin
            s0_e = $signed({1'b0, r_in.left_sample}) - $signed({1'b0, r_in.right_sample});
        end

        // Accumulate and clamp to the integral cap
        s0_ei      = s0_e * $signed({1'b0, r_gain_i});
        s0_acc_raw = s0_ei + 20'(r_integral);
        s0_cap_u   = 14'(r_int_limit) * 14'(pdd_pkg::INT_SCALE);
        s0_cap     = $signed({6'b0, s0_cap_u});
        if (s0_acc_raw > s0_cap) begin
            s0_acc_clamp = s0_cap;
        end else if (s0_acc_raw < -s0_cap) begin
            s0_acc_clamp = -s0_cap;
        end else begin
            s0_acc_clamp = s0_acc_raw;
        end

        s0_d = 12'(s0_e) - 12'(r_last_error);

        if (r_in.center_sample > {2'b00, r_center_high}) begin
            s0_base = 11'(pdd_pkg::MARKER_SPEED);
        end else begin
            s0_base = {1'b0, r_cruise_speed, 2'b00};
        end
    end

    // PID sum and drive numerators, held to the useful range and offset to >= 0
    function automatic logic [15:0] sat_num(input logic signed [23:0] n);
        logic [15:0] m;
        if (n < pdd_pkg::NUM_LOW) begin
            m = '0;
        end else if (n > pdd_pkg::NUM_HIGH) begin
            m = 16'(pdd_pkg::NUM_HIGH - pdd_pkg::NUM_LOW);
        end else begin
            m = 16'(n - 24'(pdd_pkg::NUM_LOW));
        end
        return m;
    endfunction

    logic signed [19:0] sa_pk;
    logic signed [22:0] sa_p5, sa_total;
    logic signed [20:0] sa_dk;
    logic [15:0]        sa_b50;
    logic signed [23:0] sa_nl, sa_nr;

    always_comb begin
        sa_pk    = r_a_e * $signed({1'b0, r_gain_p});
        sa_p5    = (23'(sa_pk) <<< 2) + 23'(sa_pk);
        sa_dk    = r_a_d * $signed({1'b0, r_gain_d});
        sa_total = sa_p5 + 23'(sa_dk) + 23'(r_a_acc);
        sa_b50   = 16'(r_a_base) * 16'(pdd_pkg::INT_SCALE);
        sa_nl    = $signed({8'b0, sa_b50}) + 24'(sa_total);
        sa_nr    = $signed({8'b0, sa_b50}) - 24'(sa_total);
    end

    // Divide by 50, keep the slower wheel, clamp and scale to duty
    function automatic logic [7:0] to_duty(input logic signed [11:0] drive);
        logic [7:0] duty;
        if (drive < 12'sd0) begin
            duty = '0;
        end else if (drive > 12'(pdd_pkg::DRIVE_MAX)) begin
            duty = 8'(pdd_pkg::DRIVE_MAX / 4);
        end else begin
            duty = drive[9:2];
        end
        return duty;
    endfunction

    logic [32:0]        sb_prod_l, sb_prod_r;
    logic [10:0]        sb_ql, sb_qr;
    logic signed [11:0] sb_dl, sb_dr, sb_base;
    pdd_pkg::t_out_beat sb_out;

    always_comb begin
        sb_prod_l = 33'(r_b_ml) * 33'(pdd_pkg::DIV50_MUL);
        sb_prod_r = 33'(r_b_mr) * 33'(pdd_pkg::DIV50_MUL);
        sb_ql     = sb_prod_l[pdd_pkg::DIV50_SHIFT +: 11];
        sb_qr     = sb_prod_r[pdd_pkg::DIV50_SHIFT +: 11];
        sb_base   = $signed({1'b0, r_b_base});
        // Quotients carry the numerator offset of one
        sb_dl     = $signed({1'b0, sb_ql}) - 12'sd1;
        sb_dr     = $signed({1'b0, sb_qr}) - 12'sd1;
        if (sb_ql > sb_qr) begin
            sb_dl = sb_base;
        end else begin
            sb_dr = sb_base;
        end
        sb_out.left_duty  = to_duty(sb_dl);
        sb_out.right_duty = to_duty(sb_dr);
    end

    // Control registers: config, state, valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p       <= '0;
            r_gain_i       <= '0;
            r_gain_d       <= '0;
            r_cruise_speed <= '0;
            r_left_thr     <= '0;
            r_right_thr    <= '0;
            r_center_high  <= '0;
            r_int_limit    <= '0;
            r_last_error   <= '0;
            r_integral     <= '0;
            r_in_valid     <= 1'b0;
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (pdd_pkg::t_cfg_idx'(i_cfg_index))
                    pdd_pkg::CFG_GAIN_P:          r_gain_p       <= i_cfg_data;
                    pdd_pkg::CFG_GAIN_I:          r_gain_i       <= i_cfg_data;
                    pdd_pkg::CFG_GAIN_D:          r_gain_d       <= i_cfg_data;
                    pdd_pkg::CFG_CRUISE_SPEED:    r_cruise_speed <= i_cfg_data;
                    pdd_pkg::CFG_LEFT_THRESHOLD:  r_left_thr     <= i_cfg_data;
                    pdd_pkg::CFG_RIGHT_THRESHOLD: r_right_thr    <= i_cfg_data;
                    pdd_pkg::CFG_CENTER_HIGH:     r_center_high  <= i_cfg_data;
                    pdd_pkg::CFG_INTEGRAL_LIMIT:  r_int_limit    <= i_cfg_data;
                    default: ;
                endcase
            end
            // Advance valids
            if (in_rdy) begin
                r_in_valid <= i_in_valid;
            end
            if (a_rdy) begin
                r_a_valid <= r_in_valid;
                // Update state once per beat as it leaves the input register
                if (r_in_valid) begin
                    r_last_error <= s0_e;
                    r_integral   <= 15'(s0_acc_clamp);
                end
            end
            if (b_rdy) begin
                r_b_valid <= r_a_valid;
            end
            if (out_rdy) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_rdy) begin
            r_in <= i_in_beat;
        end
        if (a_rdy) begin
            r_a_e    <= s0_e;
            r_a_d    <= s0_d;
            r_a_acc  <= 15'(s0_acc_clamp);
            r_a_base <= s0_base;
        end
        if (b_rdy) begin
            r_b_ml   <= sat_num(sa_nl);
            r_b_mr   <= sat_num(sa_nr);
            r_b_base <= r_a_base;
        end
        if (out_rdy) begin
            r_out <= sb_out;
        end
    end

    // Integral never leaves the largest possible cap
    a_integral_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integral <= 15'sd12750) && (r_integral >= -15'sd12750))
        else $error("integral outside cap range");

    // State moves only when a beat leaves the input register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(a_rdy && r_in_valid) |=> $stable(r_last_error) && $stable(r_integral))
        else $error("state changed without a beat");

    // Stored error and integral match those handed to the next stage
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_rdy && r_in_valid) |=> (r_last_error == r_a_e) && (r_integral == r_a_acc))
        else $error("state and stage A disagree");

    // A stalled output keeps the stage behind it full
    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_out_valid && !i_out_ready) |=> r_b_valid)
        else $error("beat dropped behind stalled output");

    // Duties stay within the clamped range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.left_duty <= 8'd250) && (r_out.right_duty <= 8'd250))
        else $error("duty out of range");

endmodule
